FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ASSERT_CLK_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: rtl/i2cdr_pkg.sv
// Package for the I2C display byte receiver: beat types and constants.
// No dependencies; used by every module of the block.
`default_nettype none

package i2cdr_pkg;

  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 4;
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_RESET   = 7'd60;
  // Control byte flags
  localparam int unsigned CTRL_CO_BIT = 7;
  localparam int unsigned CTRL_DC_BIT = 6;

  // One line sample
  typedef struct packed {
    logic clock_line;
    logic data_line;
  } i2cdr_in_t;

  // One result beat
  typedef struct packed {
    logic              ack_active;
    logic              ack_changed;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_is_data;
  } i2cdr_out_t;

endpackage

`default_nettype wire

FILE: rtl/i2cdr_core.sv
// Bus protocol state and per-sample next-state logic of the receiver.
// Depends on i2cdr_pkg.
`default_nettype none

module i2cdr_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire i2cdr_pkg::i2cdr_in_t       sample,
  input  wire logic [i2cdr_pkg::ADDR_W-1:0] slave_address,
  output i2cdr_pkg::i2cdr_out_t           result
);
  import i2cdr_pkg::*;

  logic              last_clock_r, last_clock_nxt;
  logic              last_data_r, last_data_nxt;
  logic              in_xfer_r, in_xfer_nxt;
  logic              await_addr_r, await_addr_nxt;
  logic              addressed_r, addressed_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic              taken_r, taken_nxt;
  logic              ack_r, ack_nxt;
  logic              want_ctrl_r, want_ctrl_nxt;
  logic              ctrl_each_r, ctrl_each_nxt;
  logic              is_data_r, is_data_nxt;
  logic              pv;
  logic              scl, sda;

  assign scl = sample.clock_line;
  assign sda = sample.data_line;

  // Next state for one sample
  always_comb begin
    last_clock_nxt = last_clock_r;
    last_data_nxt  = last_data_r;
    in_xfer_nxt    = in_xfer_r;
    await_addr_nxt = await_addr_r;
    addressed_nxt  = addressed_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    taken_nxt      = taken_r;
    ack_nxt        = ack_r;
    want_ctrl_nxt  = want_ctrl_r;
    ctrl_each_nxt  = ctrl_each_r;
    is_data_nxt    = is_data_r;
    pv             = 1'b0;
    if (scl != last_clock_r || sda != last_data_r) begin
      last_clock_nxt = scl;
      last_data_nxt  = sda;
      if (last_clock_r && scl) begin
        // SDA moved with SCL high: START or STOP
        addressed_nxt = 1'b0;
        bit_cnt_nxt   = '0;
        taken_nxt     = 1'b0;
        ack_nxt       = 1'b0;
        if (!sda) begin
          in_xfer_nxt    = 1'b1;
          await_addr_nxt = 1'b1;
          shift_nxt      = '0;
        end else begin
          in_xfer_nxt = 1'b0;
        end
      end else if (in_xfer_r) begin
        if (!last_clock_r && scl) begin
          // Rising SCL: shift a bit, or close the ACK clock
          if (bit_cnt_r < BITS_PER_BYTE) begin
            shift_nxt   = {shift_r[BYTE_W-2:0], sda};
            bit_cnt_nxt = bit_cnt_r + 1'b1;
          end else begin
            bit_cnt_nxt = '0;
            taken_nxt   = 1'b0;
          end
        end else if (last_clock_r && !scl) begin
          // Falling SCL: judge a full byte once, else drop ACK
          if (bit_cnt_r == BITS_PER_BYTE) begin
            if (!taken_r) begin
              taken_nxt = 1'b1;
              if (await_addr_r) begin
                await_addr_nxt = 1'b0;
                addressed_nxt  = (shift_r[BYTE_W-1:1] == slave_address);
                ack_nxt        = addressed_nxt;
                if (addressed_nxt) begin
                  want_ctrl_nxt = 1'b1;
                  ctrl_each_nxt = 1'b0;
                  is_data_nxt   = 1'b0;
                end
              end else if (!addressed_r) begin
                ack_nxt = 1'b0;
              end else if (want_ctrl_r) begin
                ctrl_each_nxt = shift_r[CTRL_CO_BIT];
                is_data_nxt   = shift_r[CTRL_DC_BIT];
                want_ctrl_nxt = 1'b0;
                ack_nxt       = 1'b1;
              end else begin
                pv      = 1'b1;
                ack_nxt = 1'b1;
                if (ctrl_each_r) begin
                  want_ctrl_nxt = 1'b1;
                end
              end
            end
          end else begin
            ack_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Result beat for this sample
  always_comb begin
    result.ack_active      = ack_nxt;
    result.ack_changed     = ack_nxt ^ ack_r;
    result.payload_valid   = pv;
    result.payload_byte    = pv ? shift_r : '0;
    result.payload_is_data = pv & is_data_r;
  end

  // State registers advance only when a sample is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_clock_r <= 1'b1;
      last_data_r  <= 1'b1;
      in_xfer_r    <= 1'b0;
      await_addr_r <= 1'b0;
      addressed_r  <= 1'b0;
      shift_r      <= '0;
      bit_cnt_r    <= '0;
      taken_r      <= 1'b0;
      ack_r        <= 1'b0;
      want_ctrl_r  <= 1'b0;
      ctrl_each_r  <= 1'b0;
      is_data_r    <= 1'b0;
    end else if (fire) begin
      last_clock_r <= last_clock_nxt;
      last_data_r  <= last_data_nxt;
      in_xfer_r    <= in_xfer_nxt;
      await_addr_r <= await_addr_nxt;
      addressed_r  <= addressed_nxt;
      shift_r      <= shift_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      taken_r      <= taken_nxt;
      ack_r        <= ack_nxt;
      want_ctrl_r  <= want_ctrl_nxt;
      ctrl_each_r  <= ctrl_each_nxt;
      is_data_r    <= is_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cdr_outreg.sv
// Result register of the receiver: holds one beat until the sink takes it.
// Depends on i2cdr_pkg.
`default_nettype none

module i2cdr_outreg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire i2cdr_pkg::i2cdr_out_t load_data,
  output logic                       ready,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output i2cdr_pkg::i2cdr_out_t      out_data
);
  import i2cdr_pkg::*;

  logic       valid_r;
  i2cdr_out_t data_r;

  // Free when empty or when the held beat leaves this cycle
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2c_slave_display_byte_receiver.sv
// Top level of the I2C slave display byte receiver.
// Depends on i2cdr_pkg, i2cdr_core and i2cdr_outreg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------
//   in       | in_valid / in_stall  | in_data   (SCL, SDA sample)
//   out      | out_valid / out_stall| out_data  (ACK, payload byte)
//   cfg      | cfg_wr_en            | cfg_wr_data (slave address)
//
// One sample in, one result beat out, at one beat per cycle sustained while
// out_stall is low. A sample passes through the input register, then the
// result register that the protocol logic loads. Reset is synchronous and
// active low. A stalled result holds the input register, and in_stall
// rises only while both registers are full.
`default_nettype none

module i2c_slave_display_byte_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire i2cdr_pkg::i2cdr_in_t          in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output i2cdr_pkg::i2cdr_out_t              out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [i2cdr_pkg::ADDR_W-1:0]  cfg_wr_data
);
  import i2cdr_pkg::*;

  logic              s1_valid_r;
  i2cdr_in_t         s1_data_r;
  logic [ADDR_W-1:0] addr_r;
  logic              out_ready;
  logic              fire;
  i2cdr_out_t        result;

  // Sample moves to the result register when that register is free
  assign fire     = s1_valid_r && out_ready;
  assign in_stall = s1_valid_r && !out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Slave address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (cfg_wr_en) begin
      addr_r <= cfg_wr_data;
    end
  end

  i2cdr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .sample        (s1_data_r),
    .slave_address (addr_r),
    .result        (result)
  );

  i2cdr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_data (result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/i2cdr_checker.sv
// Port-level checks of the I2C display byte receiver, bound to the top.
// Depends on i2cdr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cdr_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire i2cdr_pkg::i2cdr_out_t out_data
);
  import i2cdr_pkg::*;

  logic pay_on;
  logic pay_clear;

  // Payload flags of the presented beat
  assign pay_on    = out_valid && out_data.payload_valid;
  assign pay_clear = (out_data.payload_byte == '0) && !out_data.payload_is_data;

  // A stalled result beat stays and holds its value
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // A delivered payload byte is always acknowledged
  `ASSERT_CLK(a_payload_ack, clk, rst_n, pay_on |-> out_data.ack_active)

  // Without a payload, byte and kind read as zero
  `ASSERT_CLK(a_payload_zero, clk, rst_n, out_valid && !out_data.payload_valid |-> pay_clear)

  // Input never stalls while the result side drains freely
  `ASSERT_CLK(a_no_stall_free, clk, rst_n, !out_stall |-> !in_stall)

  // Right after reset the input side is open
  `ASSERT_CLK_NR(a_reset_open, clk, rst_n && $past(!rst_n) |-> !in_stall)

endmodule

bind i2c_slave_display_byte_receiver i2cdr_checker u_i2cdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
